FILE: hdl/tlg_pkg.sv
package tlg_pkg;

    // generator constants
    localparam logic [31:0] LCG_MUL  = 32'd1664525;
    localparam logic [31:0] LCG_ADD  = 32'd1013904223;
    localparam int          SEED_BIT = 28;

    // action codes on the input word
    localparam logic ACT_RESEED = 1'b0;
    localparam logic ACT_STEP   = 1'b1;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SEED = 4'b0010,
        S_STEP = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic seed_load;
        logic seed_cell;
        logic life_row;
        logic emit_row;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic col_end;
        logic row_end;
        logic out_free;
    } t_sts;

    // one step of the linear congruential generator, mod 2^32
    function automatic logic [31:0] lcg_next(logic [31:0] x);
        return x * LCG_MUL + LCG_ADD;
    endfunction

endpackage

FILE: hdl/tlg_ctrl.sv
module tlg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_action,
    output logic          o_stall,
    input  tlg_pkg::t_sts i_sts,
    output tlg_pkg::t_cmd o_cmd
);
    import tlg_pkg::*;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_action == ACT_RESEED) begin
                        o_cmd.seed_load = 1'b1;
                        n_state         = S_SEED;
                    end else begin
                        n_state = S_STEP;
                    end
                end
            end
            S_SEED: begin
                o_cmd.seed_cell = 1'b1;
                if (i_sts.col_end && i_sts.row_end) begin
                    n_state = S_EMIT;
                end
            end
            S_STEP: begin
                o_cmd.life_row = 1'b1;
                if (i_sts.row_end) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_row = 1'b1;
                    if (i_sts.row_end) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // one word at a time: input taken only when idle
    assign o_stall = (r_state != S_IDLE);

endmodule

FILE: hdl/tlg_dp.sv
module tlg_dp #(
    parameter int GRID_ROWS = 16,
    parameter int GRID_COLS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [31:0]   i_seed_value,
    input  tlg_pkg::t_cmd i_cmd,
    output tlg_pkg::t_sts o_sts,
    input  logic          i_stall,
    output logic          o_valid,
    output logic [3:0]    o_row_number,
    output logic [31:0]   o_row_cells,
    output logic          o_last_row
);
    import tlg_pkg::*;

    localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam logic [RW-1:0] ROW_LAST = RW'(GRID_ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(GRID_COLS - 1);

    typedef logic [GRID_COLS-1:0] t_row;

    t_row            r_ring [GRID_ROWS];
    t_row            n_tail;
    logic            ring_shift;
    logic [RW-1:0]   r_row;
    logic [CW-1:0]   r_col;
    logic            col_end;
    logic            row_end;
    logic            row_adv;
    logic [31:0]     r_x;
    logic [31:0]     mul_in;
    logic [31:0]     n_x;
    t_row            r_acc;
    t_row            n_acc;
    t_row            r_prev;
    t_row            r_first;
    t_row            up_row;
    t_row            dn_row;
    t_row            cur_row;
    t_row            life_out;
    logic            r_out_valid;
    logic [RW-1:0]   r_out_row;
    t_row            r_out_cells;
    logic            r_out_last;
    logic            out_free;

    assign col_end  = (r_col == COL_LAST);
    assign row_end  = (r_row == ROW_LAST);
    assign out_free = !r_out_valid || !i_stall;

    assign o_sts.col_end  = col_end;
    assign o_sts.row_end  = row_end;
    assign o_sts.out_free = out_free;

    // generator: one shared multiplier, seed or running value
    assign mul_in = i_cmd.seed_load ? i_seed_value : r_x;
    assign n_x    = lcg_next(mul_in);
    assign n_acc  = {n_x[SEED_BIT], r_acc[GRID_COLS-1:1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_load || i_cmd.seed_cell) begin
            r_x <= n_x;
        end
        if (i_cmd.seed_cell) begin
            r_acc <= n_acc;
        end
    end

    // neighbor rows for the current row, wrapping top and bottom
    assign cur_row = r_ring[0];
    assign up_row  = (r_row == '0) ? r_ring[GRID_ROWS-1] : r_prev;
    assign dn_row  = row_end ? r_first : r_ring[1];

    // life rule, one column per lane
    always_comb begin
        t_row up_l, up_r, cu_l, cu_r, dn_l, dn_r;
        logic [3:0] cnt;
        up_l = {up_row[GRID_COLS-2:0], up_row[GRID_COLS-1]};
        up_r = {up_row[0], up_row[GRID_COLS-1:1]};
        cu_l = {cur_row[GRID_COLS-2:0], cur_row[GRID_COLS-1]};
        cu_r = {cur_row[0], cur_row[GRID_COLS-1:1]};
        dn_l = {dn_row[GRID_COLS-2:0], dn_row[GRID_COLS-1]};
        dn_r = {dn_row[0], dn_row[GRID_COLS-1:1]};
        life_out = '0;
        for (int c = 0; c < GRID_COLS; c++) begin
            cnt = 4'(up_l[c]) + 4'(up_row[c]) + 4'(up_r[c])
                + 4'(cu_l[c]) + 4'(cu_r[c])
                + 4'(dn_l[c]) + 4'(dn_row[c]) + 4'(dn_r[c]);
            life_out[c] = (cnt == 4'd3) || (cur_row[c] && (cnt == 4'd2));
        end
    end

    // saved old rows for the wrap and the row above
    always_ff @(posedge i_clk) begin
        if (i_cmd.life_row) begin
            r_prev <= r_ring[0];
            if (r_row == '0) begin
                r_first <= r_ring[0];
            end
        end
    end

    // grid ring: head is the row being worked on, new rows enter at the tail
    always_comb begin
        ring_shift = 1'b0;
        n_tail     = r_ring[0];
        priority if (i_cmd.seed_cell) begin
            ring_shift = col_end;
            n_tail     = n_acc;
        end else if (i_cmd.life_row) begin
            ring_shift = 1'b1;
            n_tail     = life_out;
        end else if (i_cmd.emit_row) begin
            ring_shift = 1'b1;
            n_tail     = r_ring[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < GRID_ROWS; i++) begin
                r_ring[i] <= '0;
            end
        end else if (ring_shift) begin
            for (int i = 0; i < GRID_ROWS - 1; i++) begin
                r_ring[i] <= r_ring[i+1];
            end
            r_ring[GRID_ROWS-1] <= n_tail;
        end
    end

    // row and column counters, both wrap to zero at the end of a pass
    assign row_adv = (i_cmd.seed_cell && col_end) || i_cmd.life_row || i_cmd.emit_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            if (i_cmd.seed_cell) begin
                r_col <= col_end ? '0 : r_col + 1'b1;
            end
            if (row_adv) begin
                r_row <= row_end ? '0 : r_row + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_row) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_row) begin
            r_out_row   <= r_row;
            r_out_cells <= r_ring[0];
            r_out_last  <= row_end;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_row_number = 4'(r_out_row);
    assign o_row_cells  = 32'(r_out_cells);
    assign o_last_row   = r_out_last;

endmodule

FILE: hdl/toroidal_life_grid_engine.sv
// Toroidal Life grid engine: a wrap-around Life grid of GRID_ROWS by GRID_COLS cells.
// Input channel (i_valid / o_stall): one word carries i_action and i_seed_value.
//   action 0 reseeds the grid from the seed through a 32-bit LCG, one cell per
//   cycle; action 1 advances the grid by one generation, one row per cycle.
// Output channel (o_valid / i_stall): after either word the block sends every
//   row, row 0 first, as o_row_number / o_row_cells, with o_last_row on the last.
// Work per word (default 16 x 32 grid):
//   reseed: the accept cycle loads the seed, then the single LCG multiplier
//   produces one cell per cycle for all GRID_ROWS*GRID_COLS cells;
//   step: the accept cycle and then one row per cycle through the
//   neighbor-count lanes;
//   then the rows are sent, the dump pausing while the receiver stalls.
// A new word is taken once the last row has been loaded into the output register.
// A receiver stall holds the output word and pauses the row dump; nothing is lost.
// Reset (synchronous, active low) clears the grid to all dead, drops o_valid and
// returns the controller to idle.
module toroidal_life_grid_engine #(
    parameter int GRID_ROWS = 16,
    parameter int GRID_COLS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [31:0] i_seed_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_row_number,
    output logic [31:0] o_row_cells,
    output logic        o_last_row
);
    import tlg_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    tlg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_stall  (o_stall),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    // grid, generator and life lanes
    tlg_dp #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed_value (i_seed_value),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_row_number (o_row_number),
        .o_row_cells  (o_row_cells),
        .o_last_row   (o_last_row)
    );

endmodule
